// ----- src/wpvl_pkg.sv -----
// shared types and constants for the pose variance liveness block
`timescale 1ns / 1ps
package wpvl_pkg;
  localparam int unsigned Depth = 32;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  localparam logic [1:0] CfgWindow   = 2'd0;
  localparam logic [1:0] CfgBlink    = 2'd1;
  localparam logic [1:0] CfgVariance = 2'd2;

  localparam logic [15:0] WindowRst   = 16'd3000;
  localparam logic [12:0] BlinkRst    = 13'd819;
  localparam logic [31:0] VarianceRst = 32'd1311;
  localparam logic [12:0] RatioOne    = 13'd4096;
  localparam logic [CntW-1:0] MinFill = CntW'(4);
  localparam logic [CntW-1:0] MinWin  = CntW'(3);

  // one queued job between front and back
  typedef struct packed {
    logic [31:0]     now;
    logic [CntW-1:0] fill;
  } job_t;

  typedef enum logic [2:0] {
    BkIdle, BkRead, BkAcc, BkMul, BkSub, BkCmp, BkOut
  } bk_state_e;
endpackage

// ----- src/wpvl_front.sv -----
// front end: takes each sample, picks its ring slot and queues a scan job
`timescale 1ns / 1ps
module wpvl_front import wpvl_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [31:0]     time_i,
  input  logic [16:0]     pitch_i,
  input  logic [16:0]     yaw_i,
  input  logic [12:0]     ratio_i,
  output logic            wr_en_o,
  output logic [PtrW-1:0] wr_addr_o,
  output logic [78:0]     wr_data_o,
  output logic            job_valid_o,
  input  logic            job_ready_i,
  output job_t            job_o
);
  logic [PtrW-1:0] wp_q, wp_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic            jv_q, jv_d;
  job_t            job_q, job_d;
  logic [PtrW-1:0] wa_q, wa_d;
  logic [78:0]     wd_q, wd_d;
  logic            acc;

  assign in_ready_o  = !jv_q;
  assign acc         = in_valid_i && in_ready_o;
  // the ring entry is written only when the back takes the job
  assign wr_en_o     = jv_q && job_ready_i;
  assign wr_addr_o   = wa_q;
  assign wr_data_o   = wd_q;
  assign job_valid_o = jv_q;
  assign job_o       = job_q;

  always_comb begin
    wp_d = wp_q; fill_d = fill_q; jv_d = jv_q; job_d = job_q;
    wa_d = wa_q; wd_d = wd_q;
    if (jv_q && job_ready_i) jv_d = 1'b0;
    if (acc) begin
      wp_d = (wp_q == PtrW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (fill_q != CntW'(Depth)) fill_d = fill_q + 1'b1;
      jv_d = 1'b1;
      job_d.now  = time_i;
      job_d.fill = (fill_q != CntW'(Depth)) ? fill_q + 1'b1 : fill_q;
      wa_d = wp_q;
      wd_d = {ratio_i, yaw_i, pitch_i, time_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; fill_q <= '0; jv_q <= 1'b0;
    end else begin
      wp_q <= wp_d; fill_q <= fill_d; jv_q <= jv_d;
    end
  end
  always_ff @(posedge clk_i) begin
    job_q <= job_d; wa_q <= wa_d; wd_q <= wd_d;
  end
endmodule

// ----- src/wpvl_back.sv -----
// back end: ring memory, window scan, variance test and result register
`timescale 1ns / 1ps
module wpvl_back import wpvl_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  logic [PtrW-1:0] wr_addr_i,
  input  logic [78:0]     wr_data_i,
  input  logic            job_valid_i,
  output logic            job_ready_o,
  input  job_t            job_i,
  input  logic [15:0]     window_i,
  input  logic [12:0]     blink_i,
  input  logic [31:0]     variance_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            spoof_o
);
  logic [78:0] mem [Depth];
  logic [78:0] rd_q;
  logic [PtrW-1:0] rd_addr;

  bk_state_e st_q, st_d;
  logic [CntW-1:0] idx_q, idx_d, n_q, n_d;
  job_t job_q, job_d;
  logic signed [22:0] sp_q, sp_d, sy_q, sy_d;
  logic [38:0] spp_q, spp_d, syy_q, syy_d;
  logic [12:0] mr_q, mr_d;
  logic [45:0] d1_q, d1_d, d2_q, d2_d;   // n*Spp, n*Syy
  logic [45:0] q1_q, q1_d, q2_q, q2_d;   // Sp^2, Sy^2
  logic [43:0] lim_q, lim_d;
  logic signed [47:0] dd_q, dd_d;
  logic ov_q, ov_d, spoof_q, spoof_d, vd_q, vd_d;
  logic [31:0] age;
  logic signed [16:0] p, y;
  logic [33:0] pp, yy;

  assign rd_addr = idx_q[PtrW-1:0];
  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
    rd_q <= mem[rd_addr];
  end

  assign age = job_q.now - rd_q[31:0];
  assign p   = rd_q[48:32];
  assign y   = rd_q[65:49];
  assign pp  = 34'($signed(p) * $signed(p));
  assign yy  = 34'($signed(y) * $signed(y));

  assign job_ready_o = (st_q == BkIdle);
  assign out_valid_o = ov_q;
  assign spoof_o     = spoof_q;

  always_comb begin
    st_d = st_q; idx_d = idx_q; n_d = n_q; job_d = job_q;
    sp_d = sp_q; sy_d = sy_q; spp_d = spp_q; syy_d = syy_q; mr_d = mr_q;
    d1_d = d1_q; d2_d = d2_q; q1_d = q1_q; q2_d = q2_q; lim_d = lim_q; dd_d = dd_q;
    ov_d = ov_q; spoof_d = spoof_q; vd_d = vd_q;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (st_q)
      BkIdle: if (job_valid_i) begin
        job_d = job_i; idx_d = '0; n_d = '0;
        sp_d = '0; sy_d = '0; spp_d = '0; syy_d = '0; mr_d = RatioOne;
        st_d = BkRead;
      end
      BkRead: st_d = BkAcc;  // memory read latency
      BkAcc: begin
        if (age <= {16'd0, window_i}) begin
          n_d = n_q + 1'b1;
          sp_d = sp_q + 23'(p); sy_d = sy_q + 23'(y);
          spp_d = spp_q + 39'(pp); syy_d = syy_q + 39'(yy);
          if (rd_q[78:66] < mr_q) mr_d = rd_q[78:66];
        end
        idx_d = idx_q + 1'b1;
        st_d = (idx_q + 1'b1 == job_q.fill) ? BkMul : BkRead;
      end
      BkMul: begin
        d1_d  = 46'(spp_q * n_q);
        d2_d  = 46'(syy_q * n_q);
        q1_d  = 46'($signed(sp_q) * $signed(sp_q));
        q2_d  = 46'($signed(sy_q) * $signed(sy_q));
        lim_d = 44'(variance_i * n_q);
        st_d  = BkSub;
      end
      BkSub: begin
        dd_d = $signed({2'b0, d1_q}) - $signed({2'b0, q1_q})
             + $signed({2'b0, d2_q}) - $signed({2'b0, q2_q});
        lim_d = 44'(lim_q) ; st_d = BkCmp;
      end
      BkCmp: begin
        // second factor of n applied here: lim*n
        vd_d = (job_q.fill >= MinFill) && (n_q >= MinWin) &&
               (dd_q < $signed({1'b0, 47'(lim_q * n_q)})) && (mr_q > blink_i);
        st_d = BkOut;
      end
      BkOut: if (!ov_q) begin
        ov_d = 1'b1; spoof_d = vd_q; st_d = BkIdle;
      end
      default: st_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BkIdle; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; ov_q <= ov_d;
    end
  end
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; n_q <= n_d; job_q <= job_d; sp_q <= sp_d; sy_q <= sy_d;
    spp_q <= spp_d; syy_q <= syy_d; mr_q <= mr_d; d1_q <= d1_d; d2_q <= d2_d;
    q1_q <= q1_d; q2_q <= q2_d; lim_q <= lim_d; dd_q <= dd_d; spoof_q <= spoof_d;
    vd_q <= vd_d;
  end
endmodule

// ----- src/windowed_pose_variance_liveness.sv -----
// top level of the windowed pose variance liveness checker
`timescale 1ns / 1ps
// usage:
// - s_axis carries one pose sample per word; m_axis returns one verdict word
//   per sample, in order
// - cfg channel writes window length (0), blink threshold (1) and variance
//   limit (2); write only while idle, other indexes are dropped
// - the front takes the sample and queues it as a scan job in a one-entry
//   slot; the back writes it into the 32 entry ring when it takes the job,
//   scans the written entries, read then accumulate for each (memory read
//   port), then steps through multiply, subtract, compare and output
// - the back works on one sample at a time, and the next sample is taken
//   while a verdict waits
// - a stalled receiver holds the verdict register; the back then holds in
//   its output state and the front slot fills, dropping tready
// - reset clears pointers, fill count, handshakes and restores register
//   defaults; ring contents need no clearing since only written entries
//   are scanned
module windowed_pose_variance_liveness import wpvl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [79:0] s_axis_tdata_i,   // time_ms, pitch, yaw, eye_ratio, pad
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // live flag, spoof flag, pad
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  logic [15:0] window_q;
  logic [12:0] blink_q;
  logic [31:0] variance_q;
  logic wr_en, job_valid, job_ready, spoof;
  logic [PtrW-1:0] wr_addr;
  logic [78:0] wr_data;
  job_t job;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WindowRst; blink_q <= BlinkRst; variance_q <= VarianceRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgWindow:   window_q   <= cfg_data_i[15:0];
        CfgBlink:    blink_q    <= cfg_data_i[12:0];
        CfgVariance: variance_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  wpvl_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid_i), .in_ready_o(s_axis_tready_o),
    .time_i(s_axis_tdata_i[31:0]), .pitch_i(s_axis_tdata_i[48:32]),
    .yaw_i(s_axis_tdata_i[65:49]), .ratio_i(s_axis_tdata_i[78:66]),
    .wr_en_o(wr_en), .wr_addr_o(wr_addr), .wr_data_o(wr_data),
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  wpvl_back u_back (
    .clk_i, .rst_ni,
    .wr_en_i(wr_en), .wr_addr_i(wr_addr), .wr_data_i(wr_data),
    .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .window_i(window_q), .blink_i(blink_q), .variance_i(variance_q),
    .out_valid_o(m_axis_tvalid_o), .out_ready_i(m_axis_tready_i), .spoof_o(spoof)
  );

  assign m_axis_tdata_o = {6'd0, spoof, !spoof};
endmodule

// ----- bench/tb_top.sv -----
// self-checking bench for the windowed pose variance liveness block
`timescale 1ns / 1ps

// holds the ring and register copies and the verdicts still owed by the block
class liveness_board;
  logic [31:0] hist_time[32];
  logic signed [16:0] hist_pitch[32];
  logic signed [16:0] hist_yaw[32];
  logic [12:0] hist_ratio[32];
  int unsigned wr_ptr;
  int unsigned filled;
  logic [15:0] win_len;
  logic [12:0] blink_lvl;
  logic [31:0] var_lim;
  bit verdict_q[$];   // 1 = spoof
  int errors;

  function new();
    wr_ptr = 0;
    filled = 0;
    win_len = wpvl_pkg::WindowRst;
    blink_lvl = wpvl_pkg::BlinkRst;
    var_lim = wpvl_pkg::VarianceRst;
    errors = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [31:0] val);
    case (idx)
      wpvl_pkg::CfgWindow:   win_len = val[15:0];
      wpvl_pkg::CfgBlink:    blink_lvl = val[12:0];
      wpvl_pkg::CfgVariance: var_lim = val;
      default: ;
    endcase
  endfunction

  // store the sample and work out whether the window looks like a still photo
  function void note_sample(logic [79:0] w);
    logic [31:0] age;
    longint sp, spp, sy, syy, n, p, y, diff, lim;
    int unsigned min_r;
    bit spoof;
    sp = 0; spp = 0; sy = 0; syy = 0; n = 0;
    min_r = 4096;
    spoof = 0;
    hist_time[wr_ptr] = w[31:0];
    hist_pitch[wr_ptr] = w[48:32];
    hist_yaw[wr_ptr] = w[65:49];
    hist_ratio[wr_ptr] = w[78:66];
    wr_ptr = (wr_ptr + 1) % 32;
    if (filled < 32) filled++;
    if (filled >= 4) begin
      for (int i = 0; i < filled; i++) begin
        age = w[31:0] - hist_time[i];
        if (age <= {16'd0, win_len}) begin
          p = hist_pitch[i];
          y = hist_yaw[i];
          sp += p; spp += p * p; sy += y; syy += y * y;
          if (hist_ratio[i] < min_r) min_r = hist_ratio[i];
          n++;
        end
      end
      if (n >= 3) begin
        diff = (n * spp - sp * sp) + (n * syy - sy * sy);
        lim = longint'(var_lim) * n * n;
        spoof = (diff < lim) && (min_r > blink_lvl);
      end
    end
    verdict_q.insert(verdict_q.size(), spoof);
  endfunction

  task check_verdict(logic [7:0] w);
    bit exp_spoof;
    if (verdict_q.size() == 0) begin
      report("verdict with nothing pending");
      return;
    end
    exp_spoof = verdict_q.pop_front();
    if (w[0] !== !exp_spoof) report($sformatf("live %b, want %b", w[0], !exp_spoof));
    if (w[1] !== exp_spoof) report($sformatf("spoof %b, want %b", w[1], exp_spoof));
  endtask

  task report(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask
endclass

module tb_top;
  import wpvl_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid_i = 0;
  logic        s_axis_tready_o;
  logic [79:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 0;
  logic [7:0]  m_axis_tdata_o;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  liveness_board board;
  bit calm;            // no idling on either side
  bit hold_recv;       // long receiver hold-off
  logic [31:0] clock_ms;
  int sent;

  always #10 clk_i = ~clk_i;

  windowed_pose_variance_liveness DUT (.*);

  // verdict side: random stalls, plus one long hold-off to fill the block
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      m_axis_tready_i <= !hold_recv && (calm || $urandom_range(99) >= 35);
    end
  end

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) board.check_verdict(m_axis_tdata_o);

  function automatic logic [16:0] rand_angle();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 17'h10000;              // most negative, out of range
    if (r == 1) return 17'h0FFFF;              // most positive, out of range
    if (r < 5) return 17'($signed($urandom_range(92160)) - 46080);
    return 17'($signed($urandom_range(40)) - 20);   // nearly still head
  endfunction

  // driven at the falling edge; back to back words reassign tvalid there
  task automatic send_sample(logic [31:0] t, logic [16:0] p, logic [16:0] y,
                             logic [12:0] r);
    while (!calm && $urandom_range(99) < 35) @(negedge clk_i);
    s_axis_tdata_i = {1'b0, r, y, p, t};
    s_axis_tvalid_i = 1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_sample(s_axis_tdata_i);
    sent++;
    @(negedge clk_i);
    s_axis_tvalid_i = 0;
  endtask

  // only while nothing is pending in the block
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    while (board.verdict_q.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  // a still or moving burst with advancing timestamps and occasional long gaps
  task automatic random_burst(int cnt, bit still);
    logic [16:0] base_p, base_y;
    base_p = rand_angle();
    base_y = rand_angle();
    for (int i = 0; i < cnt; i++) begin
      clock_ms += $urandom_range(4) == 0 ? $urandom_range(5000) : $urandom_range(200);
      if (still)
        send_sample(clock_ms, base_p + 17'($urandom_range(3)), base_y - 17'($urandom_range(3)),
                    13'($urandom_range(4096, 900)));
      else
        send_sample(clock_ms, rand_angle(), rand_angle(),
                    $urandom_range(9) == 0 ? 13'($urandom) : 13'($urandom_range(4096)));
    end
  endtask

  initial begin
    board = new();
    calm = 0;
    hold_recv = 0;
    sent = 0;
    clock_ms = 32'hFFFF_F000;   // wraps early in the run
    repeat (5) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // directed: too few samples, still head, blink, extremes, wrap, future stamps
    send_sample(32'hFFFF_FF00, 17'd0, 17'd0, 13'd4096);
    send_sample(32'hFFFF_FF80, 17'd0, 17'd0, 13'd4096);
    send_sample(32'hFFFF_FFF0, 17'd0, 17'd0, 13'd4096);
    send_sample(32'h0000_0010, 17'd0, 17'd0, 13'd4096);   // wrapped age, still: spoof
    send_sample(32'h0000_0020, 17'd0, 17'd0, 13'd8191);   // ratio above one
    send_sample(32'h0000_0030, 17'd0, 17'd0, 13'd100);    // blink
    send_sample(32'h0000_0040, 17'h10000, 17'h0FFFF, 13'd4096);
    send_sample(32'h0000_0050, 17'h0FFFF, 17'h10000, 13'd4096);
    send_sample(32'h0000_0060, 17'd46080, -17'sd46080, 13'd0);
    send_sample(32'h8000_0000, 17'd5, 17'd5, 13'd4096);   // far jump, window drops
    send_sample(32'h7FFF_0000, 17'd5, 17'd5, 13'd4096);   // from the past
    send_sample(32'h8000_0010, 17'd5, 17'd5, 13'd4096);
    send_sample(32'h8000_0020, 17'd5, 17'd5, 13'd4096);

    write_reg(CfgWindow, 32'hFFFF_0000);   // window 0
    write_reg(CfgVariance, 32'hFFFF_FFFF);
    send_sample(32'h8000_0020, 17'd5, 17'd5, 13'd4096);
    send_sample(32'h8000_0020, 17'd7, 17'd5, 13'd4096);
    write_reg(CfgWindow, 32'd65535);
    write_reg(CfgBlink, 32'd4096);          // never spoof
    send_sample(32'h8000_0030, 17'd5, 17'd5, 13'd4096);
    write_reg(CfgBlink, 32'd0);
    write_reg(CfgVariance, 32'd0);
    send_sample(32'h8000_0040, 17'd5, 17'd5, 13'd4096);
    write_reg(3, 32'hFFFF_FFFF);            // unknown index, dropped
    send_sample(32'h8000_0050, 17'd5, 17'd5, 13'd4096);

    // receiver holds off while the sender keeps offering
    hold_recv = 1;
    fork
      random_burst(8, 0);
      begin repeat (400) @(negedge clk_i); hold_recv = 0; end
    join

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(CfgWindow, 32'(WindowRst));
          write_reg(CfgBlink, 32'(BlinkRst));
          write_reg(CfgVariance, 32'h0010_0000);
        end
        1: write_reg(CfgWindow, 32'd65535);
        2: write_reg(CfgVariance, $urandom);
        3: write_reg(CfgBlink, $urandom_range(4096));
        4: write_reg(CfgWindow, $urandom_range(600));
        default: write_reg(CfgVariance, 32'hFFFF_FFFF);
      endcase
      calm = (ph == 2);
      while (sent < 120 + ph * 316) random_burst($urandom_range(3, 30), $urandom_range(9) < 6);
    end
    calm = 0;

    while (board.verdict_q.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (board.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
